// File: design/slrw_pkg.sv
// ----------------------------------------------------------------------------
// slrw_pkg
// Shared widths, register indexes and reset values for the LCD register writer.
// ----------------------------------------------------------------------------
`default_nettype none

package slrw_pkg;

	// Widths of the fixed fields.
	localparam int unsigned FIELD_W   = 16;
	localparam int unsigned HALF_W    = 16;
	localparam int unsigned DEV_ID_W  = 6;
	localparam int unsigned GAP_W     = 8;
	localparam int unsigned WAIT_W    = HALF_W + GAP_W;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 16;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// Configuration register indexes.
	localparam cfg_idx_t CFG_HALF_PERIOD = 2'd0;
	localparam cfg_idx_t CFG_DEVICE_ID   = 2'd1;
	localparam cfg_idx_t CFG_GAP_FACTOR  = 2'd2;

	// Register reset values.
	localparam logic [HALF_W-1:0]   HALF_RESET = 16'd25;
	localparam logic [DEV_ID_W-1:0] ID_RESET   = 6'h1d;
	localparam logic [GAP_W-1:0]    GAP_RESET  = 8'd10;

	// Input item modes.
	localparam logic MODE_TICK  = 1'b0;
	localparam logic MODE_START = 1'b1;

endpackage

`default_nettype wire

// File: design/spi_lcd_register_writer_top.sv
// ----------------------------------------------------------------------------
// spi_lcd_register_writer_top
// Tick-driven three-wire serial writer for LCD panel control registers.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake            | Content
//  --------+-----------+----------------------+-----------------------------------
//  in      | input     | in_valid / in_stall  | mode, reg_index, reg_value
//  out     | output    | out_valid / out_stall| pin levels, busy, done, rejected
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Every input item produces exactly one result item. An item is taken into an
// input register, then the sequencer step is applied and the result lands in
// the output register; one item is accepted every cycle while the input stage
// does not stall. The input stage only stalls when it is full and the
// output register holds an item that the consumer is stalling. The reset state
// is idle with the sequencer's three pin levels high and the configuration at
// its defaults. Configuration writes are always accepted and take effect at once.
// ----------------------------------------------------------------------------
`default_nettype none

module spi_lcd_register_writer_top #(
	parameter int unsigned WORD_BITS = 16,
	parameter int unsigned ID_BITS   = 6
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// Input item channel.
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           mode,
	input  wire logic [slrw_pkg::FIELD_W-1:0]   reg_index,
	input  wire logic [slrw_pkg::FIELD_W-1:0]   reg_value,
	// Result item channel.
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic                                chip_select,
	output logic                                serial_clock,
	output logic                                serial_data,
	output logic                                busy_res,
	output logic                                done_res,
	output logic                                rejected,
	// Configuration write channel.
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire slrw_pkg::cfg_idx_t             cfg_index,
	input  wire logic [slrw_pkg::CFG_DAT_W-1:0] cfg_data
);

	// Each frame is the device id, the RS bit, the RW bit and one word.
	localparam int unsigned FRAME_BITS = ID_BITS + 2 + WORD_BITS;
	localparam int unsigned POS_W      = $clog2(FRAME_BITS + 1);
	localparam int unsigned FIDX_W     = $clog2(FRAME_BITS);
	localparam int unsigned IDW_W      = ID_BITS + slrw_pkg::DEV_ID_W;

	// Sequencer phase codes.
	localparam int unsigned PH_W = 4;
	localparam logic [PH_W-1:0] PH_IDLE   = 4'd0;
	localparam logic [PH_W-1:0] PH_PRE    = 4'd1;
	localparam logic [PH_W-1:0] PH_CSLOW1 = 4'd2;
	localparam logic [PH_W-1:0] PH_F1_LO  = 4'd3;
	localparam logic [PH_W-1:0] PH_F1_HI  = 4'd4;
	localparam logic [PH_W-1:0] PH_TAIL1  = 4'd5;
	localparam logic [PH_W-1:0] PH_GAP    = 4'd6;
	localparam logic [PH_W-1:0] PH_CSLOW2 = 4'd7;
	localparam logic [PH_W-1:0] PH_F2_LO  = 4'd8;
	localparam logic [PH_W-1:0] PH_F2_HI  = 4'd9;
	localparam logic [PH_W-1:0] PH_END    = 4'd10;

	// Configuration registers.
	logic [slrw_pkg::HALF_W-1:0]   half_q;
	logic [slrw_pkg::DEV_ID_W-1:0] dev_id_q;
	logic [slrw_pkg::GAP_W-1:0]    gap_q;

	// Input stage.
	logic                          valid_s1;
	logic                          mode_s1;
	logic [slrw_pkg::FIELD_W-1:0]  index_s1;
	logic [slrw_pkg::FIELD_W-1:0]  value_s1;

	// Sequencer state.
	logic [PH_W-1:0]               phase_q,  phase_d;
	logic [POS_W-1:0]              bitpos_q, bitpos_d;
	logic [slrw_pkg::WAIT_W-1:0]   wait_q,   wait_d;
	logic [WORD_BITS-1:0]          index_q;
	logic [WORD_BITS-1:0]          value_q;
	logic                          cs_q,   cs_d;
	logic                          sclk_q, sclk_d;
	logic                          sdata_q, sdata_d;
	logic                          done_d;
	logic                          rej_d;
	logic                          load_start;

	// Output register.
	logic                          out_valid_q;
	logic                          cs_o_q, sclk_o_q, sdata_o_q, busy_o_q, done_o_q, rej_o_q;

	logic                          accept_in;
	logic                          advance;

	// Step arithmetic.
	logic [slrw_pkg::HALF_W-1:0]   half_eff;
	logic [slrw_pkg::GAP_W-1:0]    gap_eff;
	logic [slrw_pkg::WAIT_W-1:0]   half_wide;
	logic [slrw_pkg::WAIT_W-1:0]   gap_ticks;
	logic [slrw_pkg::WAIT_W-1:0]   wait_dec;
	logic [POS_W-1:0]              bitpos_inc;
	logic [POS_W-1:0]              sel_pos;
	logic [POS_W-1:0]              fidx_full;
	logic                          frame2;
	logic [IDW_W-1:0]              id_wide;
	logic [FRAME_BITS-1:0]         frame_vec;
	logic                          frame_bit;

	assign cfg_ready = 1'b1;

	assign advance   = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign accept_in = in_valid && !in_stall;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q   <= slrw_pkg::HALF_RESET;
			dev_id_q <= slrw_pkg::ID_RESET;
			gap_q    <= slrw_pkg::GAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				slrw_pkg::CFG_HALF_PERIOD: half_q   <= cfg_data;
				slrw_pkg::CFG_DEVICE_ID:   dev_id_q <= cfg_data[slrw_pkg::DEV_ID_W-1:0];
				slrw_pkg::CFG_GAP_FACTOR:  gap_q    <= cfg_data[slrw_pkg::GAP_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			mode_s1  <= mode;
			index_s1 <= reg_index;
			value_s1 <= reg_value;
		end
	end

	// Delays of zero behave as one.
	assign half_eff  = (half_q == '0) ? slrw_pkg::HALF_W'(1) : half_q;
	assign gap_eff   = (gap_q == '0) ? slrw_pkg::GAP_W'(1) : gap_q;
	assign half_wide = slrw_pkg::WAIT_W'(half_eff);
	assign gap_ticks = half_wide * slrw_pkg::WAIT_W'(gap_eff);
	assign wait_dec  = (wait_q != '0) ? wait_q - slrw_pkg::WAIT_W'(1) : wait_q;
	assign bitpos_inc = bitpos_q + POS_W'(1);

	// Bit selection for the next clock-low step. Entering a frame starts at
	// position zero; otherwise the position after the current one is sent.
	assign frame2    = (phase_q == PH_CSLOW2) || (phase_q == PH_F2_HI);
	assign sel_pos   = ((phase_q == PH_CSLOW1) || (phase_q == PH_CSLOW2)) ? '0 : bitpos_inc;
	assign id_wide   = IDW_W'(dev_id_q);
	assign frame_vec = {id_wide[ID_BITS-1:0], frame2, 1'b0, frame2 ? value_q : index_q};
	assign fidx_full = POS_W'(FRAME_BITS - 1) - sel_pos;
	assign frame_bit = frame_vec[fidx_full[FIDX_W-1:0]];

	// One sequencer step per item.
	always_comb begin
		phase_d    = phase_q;
		bitpos_d   = bitpos_q;
		wait_d     = wait_q;
		cs_d       = cs_q;
		sclk_d     = sclk_q;
		sdata_d    = sdata_q;
		done_d     = 1'b0;
		rej_d      = 1'b0;
		load_start = 1'b0;
		if (mode_s1 == slrw_pkg::MODE_START) begin
			if (phase_q != PH_IDLE) begin
				rej_d = 1'b1;
			end else begin
				load_start = 1'b1;
				cs_d       = 1'b1;
				sclk_d     = 1'b1;
				sdata_d    = 1'b1;
				bitpos_d   = '0;
				wait_d     = half_wide;
				phase_d    = PH_PRE;
			end
		end else if (phase_q != PH_IDLE) begin
			wait_d = wait_dec;
			if (wait_dec == '0) begin
				unique case (phase_q)
					PH_PRE, PH_GAP: begin
						cs_d    = 1'b0;
						wait_d  = half_wide;
						phase_d = (phase_q == PH_PRE) ? PH_CSLOW1 : PH_CSLOW2;
					end
					PH_CSLOW1, PH_CSLOW2: begin
						bitpos_d = '0;
						sclk_d   = 1'b0;
						sdata_d  = frame_bit;
						wait_d   = half_wide;
						phase_d  = (phase_q == PH_CSLOW1) ? PH_F1_LO : PH_F2_LO;
					end
					PH_F1_LO, PH_F2_LO: begin
						sclk_d  = 1'b1;
						wait_d  = half_wide;
						phase_d = phase_q + PH_W'(1);
					end
					PH_F1_HI, PH_F2_HI: begin
						bitpos_d = bitpos_inc;
						wait_d   = half_wide;
						if (bitpos_inc < POS_W'(FRAME_BITS)) begin
							sclk_d  = 1'b0;
							sdata_d = frame_bit;
							phase_d = phase_q - PH_W'(1);
						end else if (phase_q == PH_F1_HI) begin
							sdata_d = 1'b1;
							phase_d = PH_TAIL1;
						end else begin
							cs_d    = 1'b1;
							phase_d = PH_END;
						end
					end
					PH_TAIL1: begin
						cs_d    = 1'b1;
						wait_d  = gap_ticks;
						phase_d = PH_GAP;
					end
					default: begin
						phase_d  = PH_IDLE;
						bitpos_d = '0;
						wait_d   = '0;
						done_d   = 1'b1;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			bitpos_q <= '0;
			wait_q   <= '0;
			cs_q     <= 1'b1;
			sclk_q   <= 1'b1;
			sdata_q  <= 1'b1;
		end else if (advance) begin
			phase_q  <= phase_d;
			bitpos_q <= bitpos_d;
			wait_q   <= wait_d;
			cs_q     <= cs_d;
			sclk_q   <= sclk_d;
			sdata_q  <= sdata_d;
		end
	end

	// The words are only read while a write is in progress.
	always_ff @(posedge clk) begin
		if (advance && load_start) begin
			index_q <= WORD_BITS'(index_s1);
			value_q <= WORD_BITS'(value_s1);
		end
	end

	// Output register: holds its item while the consumer stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cs_o_q    <= cs_d;
			sclk_o_q  <= sclk_d;
			sdata_o_q <= sdata_d;
			busy_o_q  <= (phase_d != PH_IDLE);
			done_o_q  <= done_d;
			rej_o_q   <= rej_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign chip_select  = cs_o_q;
	assign serial_clock = sclk_o_q;
	assign serial_data  = sdata_o_q;
	assign busy_res     = busy_o_q;
	assign done_res     = done_o_q;
	assign rejected     = rej_o_q;

endmodule

`default_nettype wire

// File: design/slrw_checker.sv
// ----------------------------------------------------------------------------
// slrw_checker
// Port-level checks for the LCD register writer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module slrw_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic chip_select,
	input wire logic serial_clock,
	input wire logic serial_data,
	input wire logic busy_res,
	input wire logic done_res,
	input wire logic rejected
);

	// A stalled result stays on the port unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(chip_select)
			&& $stable(serial_clock) && $stable(serial_data) && $stable(busy_res)
			&& $stable(done_res) && $stable(rejected))
		else $error("stalled result changed");

	// A completed write leaves the block idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res && !rejected)
		else $error("done reported while busy");

	// A start is only rejected while a write is in progress.
	a_rej_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected |-> busy_res)
		else $error("rejection while idle");

	// Chip select is released whenever the block is idle.
	a_idle_cs: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !busy_res |-> chip_select)
		else $error("chip select low while idle");

endmodule

bind spi_lcd_register_writer_top slrw_checker u_slrw_checker (.*);

`default_nettype wire
